@@ src/bounded_doubly_linked_list_core_macros.svh @@
// assertion macros for the bounded list core
`ifndef BOUNDED_DOUBLY_LINKED_LIST_CORE_MACROS_SVH
`define BOUNDED_DOUBLY_LINKED_LIST_CORE_MACROS_SVH

// clocked assertion with synchronous reset disable
`define BDLL_ASSERT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define BDLL_ASSERT_ALWAYS(label, clk_s, prop, msg) \
  label: assert property (@(posedge clk_s) (prop)) else $error(msg);

`endif

@@ src/bdll_pkg.sv @@
// shared types and codes of the bounded list core
package bdll_pkg;

  localparam int VAL_W = 32;

  localparam logic [3:0] ACT_FRONT  = 4'd0;
  localparam logic [3:0] ACT_BACK   = 4'd1;
  localparam logic [3:0] ACT_BEFORE = 4'd2;
  localparam logic [3:0] ACT_AFTER  = 4'd3;
  localparam logic [3:0] ACT_POPF   = 4'd4;
  localparam logic [3:0] ACT_POPB   = 4'd5;
  localparam logic [3:0] ACT_REMK   = 4'd6;
  localparam logic [3:0] ACT_DUMPF  = 4'd7;
  localparam logic [3:0] ACT_DUMPB  = 4'd8;
  localparam logic [3:0] ACT_SORTED = 4'd9;

  localparam logic [2:0] ST_DONE  = 3'd0;
  localparam logic [2:0] ST_FULL  = 3'd1;
  localparam logic [2:0] ST_EMPTY = 3'd2;
  localparam logic [2:0] ST_NOKEY = 3'd3;
  localparam logic [2:0] ST_ELEM  = 3'd4;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_ROT_L,
    OP_ROT_R,
    OP_INS,
    OP_REM
  } cell_op_t;

  typedef struct packed {
    cell_op_t               op;
    logic signed [VAL_W-1:0] new_value;
    logic signed [VAL_W-1:0] key;
  } cell_ctrl_t;

endpackage

@@ src/bdll_cell.sv @@
// one list position: value, occupancy and local compares
module bdll_cell (
  input  logic                                 clk,
  input  logic                                 rst,
  input  bdll_pkg::cell_ctrl_t                 ctrl,
  input  logic                                 tok,
  input  logic                                 mark,
  input  logic                                 left_valid,
  input  logic signed [bdll_pkg::VAL_W-1:0]    left_value,
  input  logic                                 right_valid,
  input  logic signed [bdll_pkg::VAL_W-1:0]    right_value,
  output logic                                 valid,
  output logic signed [bdll_pkg::VAL_W-1:0]    value,
  output logic                                 eq_key,
  output logic                                 eq_val,
  output logic                                 gt_val
);

  logic                              valid_next;
  logic signed [bdll_pkg::VAL_W-1:0] value_next;

  always_comb begin
    valid_next = valid;
    value_next = value;
    unique case (ctrl.op)
      bdll_pkg::OP_HOLD: begin
      end
      bdll_pkg::OP_ROT_L: begin
        valid_next = right_valid;
        value_next = right_value;
      end
      bdll_pkg::OP_ROT_R: begin
        valid_next = left_valid;
        value_next = left_value;
      end
      bdll_pkg::OP_INS: begin
        if (!mark && tok) begin
          valid_next = 1'b1;
          value_next = ctrl.new_value;
        end else if (!mark) begin
          valid_next = left_valid;
          value_next = left_value;
        end
      end
      bdll_pkg::OP_REM: begin
        if (!mark) begin
          valid_next = right_valid;
          value_next = right_value;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    value <= value_next;
  end

  assign eq_key = valid && (value == ctrl.key);
  assign eq_val = valid && (value == ctrl.new_value);
  assign gt_val = valid && (value > ctrl.new_value);

endmodule

@@ src/bounded_doubly_linked_list_core.sv @@
// key searches and sorted inserts walk a token down the row of cells one position per
// cycle; dumps rotate the whole row once around and give one element per cycle when
// the output is free and the end cell read holds an element
// throughput: one request at a time; a new request is taken once the last result
// sits in the output register
// reset: synchronous active high rst empties the list, no clearing pass is needed
module bounded_doubly_linked_list_core #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // action[3:0], value[35:4], match_key[67:36], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // item_value[31:0], status[34:32], zero pad
  output logic        m_tlast
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int VW = bdll_pkg::VAL_W;

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_APPLY, S_RES, S_DUMP} state_t;

  state_t                state;
  logic [3:0]            act;
  logic signed [VW-1:0]  val;
  logic signed [VW-1:0]  key;
  logic [CAPACITY:0]     tok;
  logic [CAPACITY-1:0]   mark;
  logic [CW-1:0]         cnt;
  logic                  ins;
  logic signed [VW-1:0]  res_value;
  logic [2:0]            res_status;
  logic                  dump_fwd;
  logic [CW-1:0]         step;
  logic [CW-1:0]         emitted;
  logic signed [VW-1:0]  out_value;
  logic [2:0]            out_status;

  bdll_pkg::cell_ctrl_t  ctrl;
  logic [CAPACITY-1:0]   cvalid;
  logic signed [VW-1:0]  cvalue [CAPACITY];
  logic [CAPACITY-1:0]   ceq_key;
  logic [CAPACITY-1:0]   ceq_val;
  logic [CAPACITY-1:0]   cgt_val;

  logic                  slot_free;
  logic                  emit;
  logic                  in_acc;
  logic [3:0]            in_act;
  logic [CAPACITY:0]     stopm;
  logic                  stop;
  logic                  found;
  logic                  after;
  logic signed [VW-1:0]  rm_val;
  logic                  look_valid;
  logic signed [VW-1:0]  look_value;

  assign slot_free = !m_tvalid || m_tready;
  assign emit      = slot_free && ((state == S_RES) || (state == S_DUMP && look_valid));
  assign s_tready  = (state == S_IDLE);
  assign in_acc    = s_tvalid && s_tready;
  assign in_act    = s_tdata[3:0];
  assign m_tdata   = {5'd0, out_status, out_value};

  always_comb begin
    ctrl.op        = bdll_pkg::OP_HOLD;
    ctrl.new_value = val;
    ctrl.key       = key;
    if (state == S_APPLY) begin
      ctrl.op = ins ? bdll_pkg::OP_INS : bdll_pkg::OP_REM;
    end else if (state == S_DUMP && slot_free) begin
      ctrl.op = dump_fwd ? bdll_pkg::OP_ROT_L : bdll_pkg::OP_ROT_R;
    end
  end

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic                 lv;
    logic signed [VW-1:0] lval;
    logic                 rv;
    logic signed [VW-1:0] rval;
    if (j == 0) begin : g_first
      assign lv   = cvalid[CAPACITY-1];
      assign lval = cvalue[CAPACITY-1];
    end else begin : g_mid
      assign lv   = cvalid[j-1];
      assign lval = cvalue[j-1];
    end
    if (j == CAPACITY-1) begin : g_last
      assign rv   = (ctrl.op == bdll_pkg::OP_ROT_L) ? cvalid[0] : 1'b0;
      assign rval = cvalue[0];
    end else begin : g_inner
      assign rv   = cvalid[j+1];
      assign rval = cvalue[j+1];
    end
    bdll_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .tok         (tok[j]),
      .mark        (mark[j]),
      .left_valid  (lv),
      .left_value  (lval),
      .right_valid (rv),
      .right_value (rval),
      .valid       (cvalid[j]),
      .value       (cvalue[j]),
      .eq_key      (ceq_key[j]),
      .eq_val      (ceq_val[j]),
      .gt_val      (cgt_val[j])
    );
  end

  always_comb begin
    stopm[CAPACITY] = 1'b1;
    for (int j = 0; j < CAPACITY; j++) begin
      if (act == bdll_pkg::ACT_SORTED) begin
        stopm[j] = !cvalid[j] || cgt_val[j] || ceq_val[j];
      end else begin
        stopm[j] = !cvalid[j] || ceq_key[j];
      end
    end
    stop  = |(tok & stopm);
    found = |(tok[CAPACITY-1:0] & cvalid);
    if (act == bdll_pkg::ACT_SORTED) begin
      after = |(tok[CAPACITY-1:0] & ceq_val);
    end else begin
      after = (act == bdll_pkg::ACT_AFTER);
    end
    rm_val = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      rm_val = rm_val | (cvalue[j] & {VW{tok[j]}});
    end
    look_valid = dump_fwd ? cvalid[0] : cvalid[CAPACITY-1];
    look_value = dump_fwd ? cvalue[0] : cvalue[CAPACITY-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            act        <= in_act;
            val        <= s_tdata[35:4];
            key        <= s_tdata[67:36];
            res_value  <= '0;
            res_status <= bdll_pkg::ST_DONE;
            tok        <= (CAPACITY+1)'(1);
            mark       <= '0;
            ins        <= 1'b1;
            dump_fwd   <= (in_act == bdll_pkg::ACT_DUMPF);
            step       <= '0;
            emitted    <= '0;
            unique case (in_act)
              bdll_pkg::ACT_FRONT, bdll_pkg::ACT_BACK: begin
                if (cnt == CW'(CAPACITY)) begin
                  res_status <= bdll_pkg::ST_FULL;
                  state      <= S_RES;
                end else begin
                  if (in_act == bdll_pkg::ACT_BACK) begin
                    tok  <= (CAPACITY+1)'(1) << cnt;
                    mark <= cvalid;
                  end
                  state <= S_APPLY;
                end
              end
              bdll_pkg::ACT_BEFORE, bdll_pkg::ACT_AFTER, bdll_pkg::ACT_SORTED: begin
                if (cnt == CW'(CAPACITY)) begin
                  res_status <= bdll_pkg::ST_FULL;
                  state      <= S_RES;
                end else begin
                  state <= S_SCAN;
                end
              end
              bdll_pkg::ACT_POPF, bdll_pkg::ACT_POPB, bdll_pkg::ACT_REMK: begin
                ins <= 1'b0;
                if (cnt == '0) begin
                  res_status <= bdll_pkg::ST_EMPTY;
                  state      <= S_RES;
                end else if (in_act == bdll_pkg::ACT_REMK) begin
                  state <= S_SCAN;
                end else begin
                  if (in_act == bdll_pkg::ACT_POPB) begin
                    tok  <= (CAPACITY+1)'(1) << (cnt - CW'(1));
                    mark <= cvalid >> 1;
                  end
                  state <= S_APPLY;
                end
              end
              bdll_pkg::ACT_DUMPF, bdll_pkg::ACT_DUMPB: begin
                if (cnt == '0) begin
                  res_status <= bdll_pkg::ST_EMPTY;
                  state      <= S_RES;
                end else begin
                  state <= S_DUMP;
                end
              end
              default: begin
                state <= S_RES;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (stop) begin
            if (act != bdll_pkg::ACT_SORTED && !found) begin
              res_status <= bdll_pkg::ST_NOKEY;
              state      <= S_RES;
            end else begin
              ins <= (act != bdll_pkg::ACT_REMK);
              if (after) begin
                tok  <= {tok[CAPACITY-1:0], 1'b0};
                mark <= mark | tok[CAPACITY-1:0];
              end
              state <= S_APPLY;
            end
          end else begin
            tok  <= {tok[CAPACITY-1:0], 1'b0};
            mark <= mark | tok[CAPACITY-1:0];
          end
        end
        S_APPLY: begin
          if (ins) begin
            cnt <= cnt + CW'(1);
          end else begin
            cnt       <= cnt - CW'(1);
            res_value <= rm_val;
          end
          state <= S_RES;
        end
        S_RES: begin
          if (slot_free) begin
            m_tlast    <= 1'b1;
            out_value  <= res_value;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        S_DUMP: begin
          if (slot_free) begin
            if (look_valid) begin
              m_tlast    <= (emitted + CW'(1) == cnt);
              out_value  <= look_value;
              out_status <= bdll_pkg::ST_ELEM;
              emitted    <= emitted + CW'(1);
            end
            step <= step + CW'(1);
            if (step == CW'(CAPACITY - 1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "bounded_doubly_linked_list_core_macros.svh"

  `BDLL_ASSERT_ALWAYS(a_cnt_bound, clk, rst || (cnt <= CW'(CAPACITY)), "count above capacity")
  `BDLL_ASSERT(a_cnt_matches, clk, rst, (state == S_IDLE) |-> ($countones(cvalid) == cnt), "count off")
  `BDLL_ASSERT(a_tok_onehot, clk, rst, (state == S_SCAN || state == S_APPLY) |-> $onehot(tok), "token")

endmodule

@@ sim/tb.sv @@
// self-checking testbench for the bounded doubly linked list core
`timescale 1ns / 100ps
module tb;

  localparam int CAP = 16;
  localparam logic [3:0] ACT_SPARE = 4'd12;
  localparam logic [3:0] ACT_TOP = 4'd15;
  localparam int LIMIT = 2000000;

  typedef struct packed {
    logic [3:0] act;
    logic [31:0] val;
    logic [31:0] key;
  } req_t;

  typedef struct packed {
    logic [31:0] val;
    logic [2:0] st;
    logic lst;
  } rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [71:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic m_tlast;

  bounded_doubly_linked_list_core #(.CAPACITY(CAP)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always #6 clk = ~clk;

  // ordered list contents kept as a plain queue
  logic signed [31:0] list_q[$];
  req_t pending_q[$];
  rsp_t expected_q[$];
  int fails = 0;
  bit stim_done = 0;
  int cycles = 0;
  bit s_tready_seen = 0;
  bit m_acc_seen = 0;
  int gap = 0;
  int stall = 0;

  function automatic int find_first(logic signed [31:0] k);
    foreach (list_q[i]) if (list_q[i] == k) return i;
    return -1;
  endfunction

  function automatic void push_rsp(logic [31:0] v, logic [2:0] s, logic l);
    rsp_t r;
    r.val = v; r.st = s; r.lst = l;
    expected_q.push_back(r);
  endfunction

  function automatic void predict_list(req_t r);
    int p;
    logic signed [31:0] v;
    v = r.val;
    if (r.act <= bdll_pkg::ACT_AFTER || r.act == bdll_pkg::ACT_SORTED) begin
      if (list_q.size() >= CAP) begin
        push_rsp(32'd0, bdll_pkg::ST_FULL, 1'b1);
        return;
      end
      case (r.act)
        bdll_pkg::ACT_FRONT: list_q.push_front(v);
        bdll_pkg::ACT_BACK: list_q.push_back(v);
        bdll_pkg::ACT_BEFORE, bdll_pkg::ACT_AFTER: begin
          p = find_first(r.key);
          if (p < 0) begin
            push_rsp(32'd0, bdll_pkg::ST_NOKEY, 1'b1);
            return;
          end
          list_q.insert(r.act == bdll_pkg::ACT_BEFORE ? p : p + 1, v);
        end
        default: begin
          p = 0;
          while (p < list_q.size() && v > list_q[p]) p++;
          if (p < list_q.size() && v == list_q[p]) p++;
          list_q.insert(p, v);
        end
      endcase
      push_rsp(32'd0, bdll_pkg::ST_DONE, 1'b1);
    end else if (r.act >= bdll_pkg::ACT_POPF && r.act <= bdll_pkg::ACT_REMK) begin
      if (list_q.size() == 0) begin
        push_rsp(32'd0, bdll_pkg::ST_EMPTY, 1'b1);
        return;
      end
      p = r.act == bdll_pkg::ACT_POPF ? 0 :
          r.act == bdll_pkg::ACT_POPB ? list_q.size() - 1 : find_first(r.key);
      if (p < 0) begin
        push_rsp(32'd0, bdll_pkg::ST_NOKEY, 1'b1);
        return;
      end
      push_rsp(list_q[p], bdll_pkg::ST_DONE, 1'b1);
      list_q.delete(p);
    end else if (r.act == bdll_pkg::ACT_DUMPF || r.act == bdll_pkg::ACT_DUMPB) begin
      if (list_q.size() == 0) push_rsp(32'd0, bdll_pkg::ST_EMPTY, 1'b1);
      for (int i = 0; i < list_q.size(); i++)
        push_rsp(r.act == bdll_pkg::ACT_DUMPF ? list_q[i] : list_q[list_q.size() - 1 - i],
                 bdll_pkg::ST_ELEM, i == list_q.size() - 1);
    end else begin
      push_rsp(32'd0, bdll_pkg::ST_DONE, 1'b1);
    end
  endfunction

  function automatic void add(logic [3:0] a, logic [31:0] v, logic [31:0] k);
    req_t r;
    r.act = a; r.val = v; r.key = k;
    pending_q.push_back(r);
  endfunction

  // small value pool so keys hit often
  function automatic logic [31:0] pick();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return $urandom_range(0, 9) - 5;
    endcase
  endfunction

  initial begin
    add(bdll_pkg::ACT_DUMPF, 0, 0);
    add(bdll_pkg::ACT_POPF, 0, 0);
    add(bdll_pkg::ACT_POPB, 0, 0);
    add(bdll_pkg::ACT_REMK, 0, 5);
    add(bdll_pkg::ACT_BEFORE, 1, 1);
    add(bdll_pkg::ACT_AFTER, 1, 1);
    add(bdll_pkg::ACT_SORTED, 32'h7fff_ffff, 0);
    add(bdll_pkg::ACT_SORTED, 32'h8000_0000, 0);
    add(bdll_pkg::ACT_SORTED, 3, 0);
    add(bdll_pkg::ACT_SORTED, 3, 0);
    add(bdll_pkg::ACT_FRONT, 32'hffff_ffff, 0);
    add(bdll_pkg::ACT_BACK, 32'h5555_aaaa, 0);
    add(bdll_pkg::ACT_BEFORE, 7, 3);
    add(bdll_pkg::ACT_AFTER, 8, 32'h5555_aaaa);
    add(bdll_pkg::ACT_AFTER, 9, 42);
    add(bdll_pkg::ACT_DUMPF, 0, 0);
    add(bdll_pkg::ACT_DUMPB, 0, 0);
    add(bdll_pkg::ACT_REMK, 0, 3);
    add(bdll_pkg::ACT_REMK, 0, 42);
    add(ACT_SPARE, 32'hffff_ffff, 32'hffff_ffff);
    add(ACT_TOP, 0, 0);
    for (int i = 0; i < 12; i++) add(bdll_pkg::ACT_BACK, i, 0);
    add(bdll_pkg::ACT_FRONT, 1, 0);
    add(bdll_pkg::ACT_SORTED, 1, 0);
    add(bdll_pkg::ACT_AFTER, 1, 0);
    add(bdll_pkg::ACT_DUMPF, 0, 0);
    add(bdll_pkg::ACT_POPB, 0, 0);
    add(bdll_pkg::ACT_POPF, 0, 0);
    for (int i = 0; i < 285; i++) begin
      int w;
      logic [3:0] a;
      w = $urandom_range(0, 99);
      if (w < 40) a = 4'($urandom_range(0, 3));
      else if (w < 55) a = bdll_pkg::ACT_SORTED;
      else if (w < 80) a = 4'($urandom_range(4, 6));
      else if (w < 95) a = 4'($urandom_range(7, 8));
      else a = 4'($urandom_range(10, 15));
      add(a, pick(), pick());
    end
    stim_done = 1;
  end

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready_seen) begin
        s_tvalid <= 1'b0;
        gap = $urandom_range(0, 7);
      end else if (!s_tvalid && pending_q.size() > 0) begin
        if (gap > 0) gap--;
        else begin
          req_t r;
          r = pending_q.pop_front();
          s_tdata <= {4'd0, r.key, r.val, r.act};
          s_tvalid <= 1'b1;
        end
      end
    end
  end

  // accept sampling at rising edge
  always @(posedge clk) begin
    s_tready_seen <= 0;
    m_acc_seen <= 0;
    cycles <= cycles + 1;
    if (!rst && s_tvalid && s_tready) begin
      req_t q;
      q.act = s_tdata[3:0];
      q.val = s_tdata[35:4];
      q.key = s_tdata[67:36];
      s_tready_seen <= 1;
      predict_list(q);
    end
    if (!rst && m_tvalid && m_tready) begin
      rsp_t e;
      m_acc_seen <= 1;
      if (expected_q.size() == 0) begin
        $error("unexpected result %h", m_tdata);
        fails++;
      end else begin
        e = expected_q.pop_front();
        if (m_tdata[31:0] !== e.val) begin
          $error("item_value exp %h got %h", e.val, m_tdata[31:0]);
          fails++;
        end
        if (m_tdata[34:32] !== e.st) begin
          $error("status exp %0d got %0d", e.st, m_tdata[34:32]);
          fails++;
        end
        if (m_tlast !== e.lst) begin
          $error("last exp %0d got %0d", e.lst, m_tlast);
          fails++;
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    if (m_acc_seen) stall = $urandom_range(0, 7);
    if (stall > 0) begin
      stall--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    wait (stim_done && pending_q.size() == 0 && !s_tvalid && expected_q.size() == 0);
    repeat (CAP * 4) @(posedge clk);
    if (fails == 0 && expected_q.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  always @(posedge clk) begin
    if (cycles >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end
endmodule
